[rtl/core/cartridge_bank_mapper_irq_assert.svh]
// Assertion macros shared by the mapper RTL.
`ifndef CARTRIDGE_BANK_MAPPER_IRQ_ASSERT_SVH
`define CARTRIDGE_BANK_MAPPER_IRQ_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CBMI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define CBMI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/cbmi_pkg.sv]
`default_nettype none
package cbmi_pkg;

  // Kinds of input word.
  typedef enum logic [2:0] {
    KIND_TICK      = 3'd0,
    KIND_CPU_READ  = 3'd1,
    KIND_CPU_WRITE = 3'd2,
    KIND_PPU_READ  = 3'd3,
    KIND_PPU_WRITE = 3'd4
  } kind_t;

  // Target memory of a translated access.
  typedef enum logic [2:0] {
    TGT_NONE = 3'd0,
    TGT_PRG  = 3'd1,
    TGT_RAM  = 3'd2,
    TGT_CHR  = 3'd3,
    TGT_NT   = 3'd4,
    TGT_OPEN = 3'd5,
    TGT_REG  = 3'd6
  } target_t;

  // Command indexes selected through the 0x8000 region.
  localparam logic [3:0] CMD_PRG0     = 4'd8;
  localparam logic [3:0] CMD_MIRROR   = 4'd12;
  localparam logic [3:0] CMD_IRQ_CTRL = 4'd13;
  localparam logic [3:0] CMD_CNT_LO   = 4'd14;
  localparam logic [3:0] CMD_CNT_HI   = 4'd15;

  // Configuration register indexes.
  localparam logic CFG_PRG_SIZE = 1'b0;
  localparam logic CFG_CHR_SIZE = 1'b1;

  // Reset values and legal ranges of the size registers.
  localparam logic [4:0] PRG_LOG2_RESET = 5'd17;
  localparam logic [4:0] CHR_LOG2_RESET = 5'd18;
  localparam logic [4:0] PRG_LOG2_MIN   = 5'd13;
  localparam logic [4:0] PRG_LOG2_MAX   = 5'd19;
  localparam logic [4:0] CHR_LOG2_MIN   = 5'd10;
  localparam logic [4:0] CHR_LOG2_MAX   = 5'd18;

  // CPU address regions (top three address bits).
  localparam logic [2:0] REGION_RAM  = 3'b011;
  localparam logic [2:0] REGION_CMD  = 3'b100;
  localparam logic [2:0] REGION_LOAD = 3'b101;
  localparam logic [2:0] REGION_C000 = 3'b110;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] bus_addr;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    target_t     target;
    logic [18:0] mapped_addr;
    logic        mem_write;
    logic        irq_line;
  } out_item_t;

endpackage
`default_nettype wire

[rtl/core/cartridge_bank_mapper_irq.sv]
`default_nettype none
// Bank-switching cartridge mapper with a 16-bit down-counting interrupt.
// Each input word is a tick, a CPU access or a PPU access; each gives one
// output word with the target memory, the translated address, a store flag
// and the interrupt level after the word. One word is taken every clock while
// the output is free: translation and register updates form one combinational
// pass from the input handshake into the output register; a word can enter
// in the same cycle that the previous result is taken. The user must
// write the size registers through the config port while idle; not enforced.
module cartridge_bank_mapper_irq (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire cbmi_pkg::in_item_t in_data,
  output logic                  out_valid,
  input  wire                   out_ready,
  output cbmi_pkg::out_item_t   out_data,
  input  wire                   cfg_we,
  input  wire                   cfg_index,
  input  wire  [4:0]            cfg_data
);
  import cbmi_pkg::*;

  `include "cartridge_bank_mapper_irq_assert.svh"

  // Mapper state.
  logic [4:0]  prg_log2;
  logic [4:0]  chr_log2;
  logic [7:0]  chr_banks [8];
  logic [5:0]  prg_banks [4];
  logic        ram_selected;
  logic        ram_enabled;
  logic [1:0]  mirror_mode;
  logic [3:0]  command_index;
  logic [15:0] irq_count;
  logic        irq_enabled;
  logic        count_enabled;
  logic        irq_pending;

  logic        in_fire;
  logic [15:0] a;
  logic [7:0]  d;
  logic [2:0]  region;
  logic [13:0] p;
  logic [4:0]  prg_log2_c;
  logic [4:0]  chr_log2_c;
  logic [18:0] prg_mask;
  logic [17:0] chr_mask;
  logic [5:0]  cpu_bank;
  logic [7:0]  ppu_bank;
  logic [10:0] nt_addr;
  logic        is_cpu;
  logic        is_ppu;
  logic        cmd_write;
  logic        load_write;
  logic        tick_count;
  logic        wrap_hit;
  logic        ctrl_ack;
  logic        irq_pending_next;
  out_item_t   res;

  // The output register frees the input side whenever it is empty or drained.
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign a      = in_data.bus_addr;
  assign d      = in_data.write_data;
  assign region = a[15:13];
  assign p      = a[13:0];
  assign is_cpu = (in_data.kind == KIND_CPU_READ) || (in_data.kind == KIND_CPU_WRITE);
  assign is_ppu = (in_data.kind == KIND_PPU_READ) || (in_data.kind == KIND_PPU_WRITE);

  // Clamp the size registers and build the address masks.
  always_comb begin
    if (prg_log2 < PRG_LOG2_MIN) prg_log2_c = PRG_LOG2_MIN;
    else if (prg_log2 > PRG_LOG2_MAX) prg_log2_c = PRG_LOG2_MAX;
    else prg_log2_c = prg_log2;
    if (chr_log2 < CHR_LOG2_MIN) chr_log2_c = CHR_LOG2_MIN;
    else if (chr_log2 > CHR_LOG2_MAX) chr_log2_c = CHR_LOG2_MAX;
    else chr_log2_c = chr_log2;
    prg_mask = ~(19'h7ffff << prg_log2_c);
    chr_mask = ~(18'h3ffff << chr_log2_c);
  end

  // CPU bank for the selected 8 KB window.
  always_comb begin
    case (region)
      REGION_RAM:  cpu_bank = prg_banks[0];
      REGION_CMD:  cpu_bank = prg_banks[1];
      REGION_LOAD: cpu_bank = prg_banks[2];
      REGION_C000: cpu_bank = prg_banks[3];
      default:     cpu_bank = prg_mask[18:13];
    endcase
  end

  assign ppu_bank = chr_banks[p[12:10]];

  // Nametable mirroring onto the 2 KB RAM.
  always_comb begin
    case (mirror_mode)
      2'd0:    nt_addr = p[10:0];
      2'd1:    nt_addr = {p[11], p[9:0]};
      2'd2:    nt_addr = {1'b0, p[9:0]};
      default: nt_addr = {1'b1, p[9:0]};
    endcase
  end

  assign cmd_write  = (in_data.kind == KIND_CPU_WRITE) && (region == REGION_CMD);
  assign load_write = (in_data.kind == KIND_CPU_WRITE) && (region == REGION_LOAD);
  assign tick_count = (in_data.kind == KIND_TICK) && count_enabled;
  assign wrap_hit   = tick_count && (irq_count == 16'h0000) && irq_enabled;
  assign ctrl_ack   = load_write && (command_index == CMD_IRQ_CTRL);

  // Translate the access into a target and an address.
  always_comb begin
    res.target      = TGT_NONE;
    res.mapped_addr = '0;
    res.mem_write   = 1'b0;
    res.irq_line    = irq_pending_next;
    if (is_cpu) begin
      if (region == REGION_RAM) begin
        if (!ram_selected) begin
          if (in_data.kind == KIND_CPU_READ) begin
            res.target      = TGT_PRG;
            res.mapped_addr = {cpu_bank, a[12:0]} & prg_mask;
          end
        end else if (ram_enabled) begin
          res.target      = TGT_RAM;
          res.mapped_addr = {6'd0, a[12:0]};
          res.mem_write   = (in_data.kind == KIND_CPU_WRITE);
        end else if (in_data.kind == KIND_CPU_READ) begin
          res.target = TGT_OPEN;
        end
      end else if (a[15]) begin
        if (in_data.kind == KIND_CPU_READ) begin
          res.target      = TGT_PRG;
          res.mapped_addr = {cpu_bank, a[12:0]} & prg_mask;
        end else if (cmd_write || load_write) begin
          res.target = TGT_REG;
        end
      end
    end else if (is_ppu) begin
      if (!p[13]) begin
        if (in_data.kind == KIND_PPU_READ) begin
          res.target      = TGT_CHR;
          res.mapped_addr = {1'b0, {ppu_bank, p[9:0]} & chr_mask};
        end
      end else if (p[13:8] != 6'h3f) begin
        res.target      = TGT_NT;
        res.mapped_addr = {8'd0, nt_addr};
        res.mem_write   = (in_data.kind == KIND_PPU_WRITE);
      end
    end
  end

  // Interrupt request after this word.
  always_comb begin
    irq_pending_next = irq_pending;
    if (wrap_hit) irq_pending_next = 1'b1;
    if (ctrl_ack) irq_pending_next = 1'b0;
  end

  // Size registers from the config port.
  always_ff @(posedge clk) begin
    if (rst) begin
      prg_log2 <= PRG_LOG2_RESET;
      chr_log2 <= CHR_LOG2_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_PRG_SIZE) prg_log2 <= cfg_data;
      if (cfg_index == CFG_CHR_SIZE) chr_log2 <= cfg_data;
    end
  end

  // Mapper registers, counter and interrupt.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) chr_banks[i] <= '0;
      for (int i = 0; i < 4; i++) prg_banks[i] <= '0;
      ram_selected  <= 1'b0;
      ram_enabled   <= 1'b0;
      mirror_mode   <= 2'd0;
      command_index <= 4'd0;
      irq_count     <= 16'd0;
      irq_enabled   <= 1'b0;
      count_enabled <= 1'b0;
      irq_pending   <= 1'b0;
    end else if (in_fire) begin
      irq_pending <= irq_pending_next;
      if (tick_count) irq_count <= irq_count - 16'd1;
      if (cmd_write) command_index <= d[3:0];
      if (load_write) begin
        if (!command_index[3]) begin
          chr_banks[command_index[2:0]] <= d;
        end else begin
          case (command_index)
            CMD_PRG0: begin
              prg_banks[0] <= d[5:0];
              ram_selected <= d[6];
              ram_enabled  <= d[7];
            end
            CMD_MIRROR: mirror_mode <= d[1:0];
            CMD_IRQ_CTRL: begin
              irq_enabled   <= d[0];
              count_enabled <= d[7];
            end
            CMD_CNT_LO: irq_count <= {irq_count[15:8], d};
            CMD_CNT_HI: irq_count <= {d, irq_count[7:0]};
            default: prg_banks[command_index[1:0]] <= d[5:0];
          endcase
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) out_data <= res;
  end

  // A counter wrap with the interrupt enabled raises the request.
  `CBMI_ASSERT_NEXT(a_wrap_raises, in_fire && wrap_hit, irq_pending, "wrap missed the request")
  // Writing the interrupt control register acknowledges the request.
  `CBMI_ASSERT_NEXT(a_ctrl_acks, in_fire && ctrl_ack, !irq_pending, "request not acknowledged")
  // The counter moves only when a word is taken.
  `CBMI_ASSERT_NEXT(a_count_hold, !in_fire, $stable(irq_count), "counter moved while idle")
  // A waiting result always shows the current interrupt level.
  `CBMI_ASSERT_NOW(a_irq_match, out_valid, out_data.irq_line == irq_pending, "stale irq level")

endmodule
`default_nettype wire
